/* hdl/jfls_pkg.sv */
// Shared types and constants for the JTAG fixed-length scan sequencer.
// No dependencies; used by the channel interfaces and the top level.
package jfls_pkg;

  localparam int unsigned IR_LENGTH = 8;
  localparam int unsigned DR_LENGTH = 40;
  localparam int unsigned DATA_W    = 40;
  localparam int unsigned LEAD_IR   = 4;
  localparam int unsigned LEAD_DR   = 2;
  localparam int unsigned TAIL      = 2;

  localparam int unsigned TOTAL_IR  = LEAD_IR + IR_LENGTH + TAIL;
  localparam int unsigned TOTAL_DR  = LEAD_DR + DR_LENGTH + TAIL;
  localparam int unsigned TOTAL_MAX = (TOTAL_IR > TOTAL_DR) ? TOTAL_IR : TOTAL_DR;
  localparam int unsigned CNT_W     = $clog2(TOTAL_MAX + 1);

  typedef enum logic [1:0] {
    CMD_IR   = 2'd0,
    CMD_DR   = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_DRIVE  = 2'd0,
    STATUS_DONE   = 2'd1,
    STATUS_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]        status;
    logic              tms_level;
    logic              tdi_level;
    logic [DATA_W-1:0] capture_data;
  } res_t;

endpackage

/* hdl/jfls_if.sv */
// Valid/ready channel interfaces for sequencer requests and results.
// Depends on jfls_pkg for field widths.
interface jfls_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [jfls_pkg::DATA_W-1:0] shift_data;
  logic                       tdo_bank;
  logic                       tdo_level_zero;
  logic                       tdo_level_one;

  modport source (output valid, command, shift_data, tdo_bank, tdo_level_zero,
                  tdo_level_one, input ready);
  modport sink   (input valid, command, shift_data, tdo_bank, tdo_level_zero,
                  tdo_level_one, output ready);
endinterface

interface jfls_res_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic                       tms_level;
  logic                       tdi_level;
  logic [jfls_pkg::DATA_W-1:0] capture_data;

  modport source (output valid, status, tms_level, tdi_level, capture_data,
                  input ready);
  modport sink   (input valid, status, tms_level, tdi_level, capture_data,
                  output ready);
endinterface

/* hdl/jtag_fixed_length_scan_sequencer_unit.sv */
// JTAG scan sequencer: one request per clock while cmd_i is ready; tick requests
// step the scan. Each accepted request is answered on res_o. The result path
// has an output register plus a skid register, so cmd_i stays ready while one
// result waits; throughput is one request per clock while the skid register is
// empty, set by the single counter/shift update done between the request and the
// result register. Scans end when the counter reaches TOTAL_IR or TOTAL_DR.
// Depends on jfls_pkg and the channel interfaces in jfls_if.sv.
module jtag_fixed_length_scan_sequencer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  jfls_req_if.sink   cmd_i,
  jfls_res_if.source res_o
);

  logic                            busy_q, busy_d;
  logic                            kind_q, kind_d;
  logic                            bank_q, bank_d;
  logic [jfls_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [jfls_pkg::DATA_W-1:0]     shift_q, shift_d;
  logic [jfls_pkg::DATA_W-1:0]     cap_q, cap_d;

  jfls_pkg::res_t res_d;
  jfls_pkg::res_t out_q;
  jfls_pkg::res_t skid_q;
  logic           out_vld_q;
  logic           skid_vld_q;

  logic acc;
  logic out_pop;

  logic [jfls_pkg::CNT_W-1:0] pre, len, idx, pre_n, len_n, idx_n, cnt_inc;
  logic                       tdo;

  assign cmd_i.ready = !skid_vld_q;
  assign acc         = cmd_i.valid && cmd_i.ready;
  assign out_pop     = out_vld_q && res_o.ready;

  always_comb begin
    busy_d  = busy_q;
    kind_d  = kind_q;
    bank_d  = bank_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    cap_d   = cap_q;
    res_d   = '{status: jfls_pkg::STATUS_REJECT, tms_level: 1'b0, tdi_level: 1'b0,
                capture_data: '0};

    pre     = kind_q ? jfls_pkg::CNT_W'(jfls_pkg::LEAD_DR) : jfls_pkg::CNT_W'(jfls_pkg::LEAD_IR);
    len     = kind_q ? jfls_pkg::CNT_W'(jfls_pkg::DR_LENGTH)
                     : jfls_pkg::CNT_W'(jfls_pkg::IR_LENGTH);
    idx     = cnt_q - pre;
    cnt_inc = cnt_q + 1'b1;
    tdo     = bank_q ? cmd_i.tdo_level_one : cmd_i.tdo_level_zero;

    if (cmd_i.command == jfls_pkg::CMD_IR || cmd_i.command == jfls_pkg::CMD_DR) begin
      if (!busy_q) begin
        busy_d  = 1'b1;
        kind_d  = cmd_i.command[0];
        bank_d  = cmd_i.tdo_bank;
        cnt_d   = '0;
        shift_d = cmd_i.shift_data;
        cap_d   = '0;
        res_d.status = jfls_pkg::STATUS_DRIVE;
      end
    end else if (cmd_i.command == jfls_pkg::CMD_TICK && busy_q) begin
      if (cnt_q >= pre && idx < len) begin
        for (int k = 0; k < int'(jfls_pkg::DATA_W); k++) begin
          if (idx == jfls_pkg::CNT_W'(k) && tdo) begin
            cap_d[k] = 1'b1;
          end
        end
        shift_d = shift_q >> 1;
      end
      cnt_d = cnt_inc;
      if (cnt_inc == pre + len + jfls_pkg::CNT_W'(jfls_pkg::TAIL)) begin
        busy_d             = 1'b0;
        res_d.status       = jfls_pkg::STATUS_DONE;
        res_d.capture_data = cap_d;
      end else begin
        res_d.status = jfls_pkg::STATUS_DRIVE;
      end
    end

    // pins for the cycle now at cnt_d
    pre_n = kind_d ? jfls_pkg::CNT_W'(jfls_pkg::LEAD_DR) : jfls_pkg::CNT_W'(jfls_pkg::LEAD_IR);
    len_n = kind_d ? jfls_pkg::CNT_W'(jfls_pkg::DR_LENGTH)
                   : jfls_pkg::CNT_W'(jfls_pkg::IR_LENGTH);
    idx_n = cnt_d - pre_n;
    if (res_d.status == jfls_pkg::STATUS_DRIVE) begin
      if (cnt_d < pre_n) begin
        res_d.tms_level = !kind_d && cnt_d < jfls_pkg::CNT_W'(2);
      end else if (idx_n < len_n) begin
        res_d.tdi_level = shift_d[0];
        res_d.tms_level = (idx_n == len_n - 1'b1);
      end else begin
        res_d.tms_level = kind_d ? (idx_n == len_n) : 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      kind_q  <= 1'b0;
      bank_q  <= 1'b0;
      cnt_q   <= '0;
      shift_q <= '0;
      cap_q   <= '0;
    end else if (acc) begin
      busy_q  <= busy_d;
      kind_q  <= kind_d;
      bank_q  <= bank_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      cap_q   <= cap_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_pop || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= acc;
      end
    end else if (acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_pop || !out_vld_q) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (acc) begin
        out_q <= res_d;
      end
    end else if (acc) begin
      skid_q <= res_d;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.status       = out_q.status;
  assign res_o.tms_level    = out_q.tms_level;
  assign res_o.tdi_level    = out_q.tdi_level;
  assign res_o.capture_data = out_q.capture_data;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full while output register empty");

  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q < (kind_q ? jfls_pkg::CNT_W'(jfls_pkg::TOTAL_DR)
                                : jfls_pkg::CNT_W'(jfls_pkg::TOTAL_IR))))
    else $error("cycle counter past end of scan");

  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !busy_q && (cmd_i.command == jfls_pkg::CMD_IR ||
                        cmd_i.command == jfls_pkg::CMD_DR))
    |=> (busy_q && cnt_q == '0))
    else $error("start request did not arm the sequencer");

  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && res_d.status == jfls_pkg::STATUS_DONE) |=> !busy_q)
    else $error("sequencer still busy after done");

endmodule
